// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every edge outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fat12_pkg.sv =====
// types, constants and helpers for the fat12 cluster table engine
// no dependencies
package fat12_pkg;

  localparam int TABLE_BYTES_DEF  = 6144;
  localparam int SECTOR_BYTES     = 512;
  localparam logic [11:0] END_MARK   = 12'hFFF;
  localparam logic [11:0] CHAIN_END  = 12'hFF8;

  typedef enum logic [2:0] {
    FN_LOAD  = 3'd0,
    FN_READ  = 3'd1,
    FN_GET   = 3'd2,
    FN_SET   = 3'd3,
    FN_FIND  = 3'd4,
    FN_FREE  = 3'd5,
    FN_CLEAN = 3'd6,
    FN_NOP   = 3'd7
  } func_t;

  typedef enum logic {
    CFG_TOTAL   = 1'b0,
    CFG_SECTORS = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOC,
    ST_RD0,
    ST_RD1,
    ST_WAIT,
    ST_EVAL,
    ST_WR1,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [12:0] byte_index;
    logic [7:0]  byte_value;
    logic [11:0] cluster;
    logic [11:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [11:0] entry;
    logic [11:0] found_cluster;
    logic [11:0] freed_count;
    logic        dirty;
  } out_item_t;

  // memory request from the sequencer to the ram
  typedef struct packed {
    logic        en;
    logic        we;
    logic [12:0] addr;
    logic [7:0]  wdata;
  } mem_req_t;

endpackage

// ===== rtl/core/fat12_ram.sv =====
// generic single port ram with registered read
// no dependencies
module fat12_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 6144
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end
endmodule

// ===== rtl/core/fat12_seq.sv =====
// operation sequencer: loads and reads table bytes, and reads, modifies and writes back table entries
// depends on fat12_pkg and assert_macros.svh
`include "assert_macros.svh"
module fat12_seq #(
  parameter int TABLE_BYTES = fat12_pkg::TABLE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  fat12_pkg::in_item_t  in_item,
  input  logic [11:0]          num_clusters,
  input  logic [3:0]           fat_sectors,
  output fat12_pkg::mem_req_t  mreq,
  input  logic [7:0]           mrdata,
  output logic                 out_valid,
  output fat12_pkg::out_item_t out_item
);
  import fat12_pkg::*;

  localparam int AW = $clog2(TABLE_BYTES);

  state_t      state_r, state_nxt;
  in_item_t    op_r, op_nxt;
  logic [11:0] cur_r, cur_nxt;      // cluster being worked on
  logic [12:0] off_r, off_nxt;      // word offset
  logic [7:0]  lo_r, lo_nxt;
  logic [11:0] cnt_r, cnt_nxt;      // chain steps
  logic        dirty_r, dirty_nxt;
  logic [7:0]  rb_r, rb_nxt;
  logic [11:0] res_r, res_nxt;
  logic [13:0] tsize_r;             // usable table bytes
  logic [12:0] ccnt;                // cluster count + 2

  // table size: sectors * 512, capped
  always_ff @(posedge clk) begin
    if ((14'(fat_sectors) << 9) > 14'(TABLE_BYTES)) begin
      tsize_r <= 14'(TABLE_BYTES);
    end else begin
      tsize_r <= 14'(fat_sectors) << 9;
    end
  end

  assign ccnt = 13'(num_clusters) + 13'd2;

  logic [12:0] off_c;
  logic        inrange;
  logic [15:0] word;
  logic [11:0] ent;
  logic [15:0] nword;

  always_comb begin
    off_c   = 13'((14'(cur_r) * 14'd3) >> 1);
    inrange = (cur_r >= 12'd2) && (13'(cur_r) < ccnt) && (14'(off_c) + 14'd1 < tsize_r);
    word    = {mrdata, lo_r};
    ent     = cur_r[0] ? word[15:4] : word[11:0];
    if (cur_r[0]) begin
      nword = {(op_r.func == FN_SET) ? op_r.entry_value : 12'h000, word[3:0]};
    end else begin
      nword = {word[15:12], (op_r.func == FN_SET) ? op_r.entry_value : 12'h000};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dirty_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    cur_r <= cur_nxt;
    off_r <= off_nxt;
    lo_r  <= lo_nxt;
    cnt_r <= cnt_nxt;
    rb_r  <= rb_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cur_nxt   = cur_r;
    off_nxt   = off_r;
    lo_nxt    = lo_r;
    cnt_nxt   = cnt_r;
    dirty_nxt = dirty_r;
    rb_nxt    = rb_r;
    res_nxt   = res_r;
    mreq      = '0;
    out_valid = 1'b0;
    out_item  = '0;
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt  = in_item;
          cur_nxt = (in_item.func == FN_FIND) ? 12'd2 : in_item.cluster;
          cnt_nxt = '0;
          rb_nxt  = '0;
          res_nxt = '0;
          case (func_t'(in_item.func))
            FN_LOAD: begin
              mreq.en    = (14'(in_item.byte_index) < 14'(TABLE_BYTES));
              mreq.we    = 1'b1;
              mreq.addr  = 13'(in_item.byte_index[AW-1:0]);
              mreq.wdata = in_item.byte_value;
              state_nxt  = ST_DONE;
            end
            FN_READ: begin
              mreq.en   = (14'(in_item.byte_index) < 14'(TABLE_BYTES));
              mreq.addr = 13'(in_item.byte_index[AW-1:0]);
              state_nxt = ST_WAIT;
            end
            FN_CLEAN: begin
              dirty_nxt = 1'b0;
              state_nxt = ST_DONE;
            end
            FN_GET, FN_SET, FN_FIND, FN_FREE: state_nxt = ST_LOC;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_WAIT: begin
        if (14'(op_r.byte_index) < 14'(TABLE_BYTES)) begin
          rb_nxt = mrdata;
        end
        state_nxt = ST_DONE;
      end
      ST_LOC: begin
        off_nxt = off_c;
        case (func_t'(op_r.func))
          FN_FIND: begin
            if (!(13'(cur_r) < ccnt)) begin
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_RD0;
            end
          end
          FN_FREE: begin
            if (cur_r >= 12'd2 && cur_r < CHAIN_END && cnt_r < num_clusters) begin
              state_nxt = ST_RD0;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          default: state_nxt = ST_RD0;
        endcase
        // out of range entries never touch memory
        if (state_nxt == ST_RD0 && !inrange) begin
          state_nxt = ST_EVAL;
        end
        if (state_nxt == ST_RD0) begin
          mreq.en   = 1'b1;
          mreq.addr = off_c;
        end
      end
      ST_RD0: begin
        // low byte arrives while the high byte is requested
        lo_nxt    = mrdata;
        mreq.en   = 1'b1;
        mreq.addr = off_r + 13'd1;
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        // ram idle, high byte stays on mrdata
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        // lo_r and mrdata hold the word when in range
        case (func_t'(op_r.func))
          FN_GET: begin
            res_nxt   = inrange ? ent : END_MARK;
            state_nxt = ST_DONE;
          end
          FN_FIND: begin
            if (inrange && ent == 12'h000) begin
              res_nxt   = cur_r;
              state_nxt = ST_DONE;
            end else if (cur_r == 12'hFFF) begin
              state_nxt = ST_DONE;
            end else begin
              cur_nxt   = cur_r + 12'd1;
              state_nxt = ST_LOC;
            end
          end
          default: begin
            // set or free step
            if (inrange) begin
              mreq.en    = 1'b1;
              mreq.we    = 1'b1;
              mreq.addr  = off_r;
              mreq.wdata = nword[7:0];
              lo_nxt     = nword[15:8];
              dirty_nxt  = 1'b1;
              state_nxt  = ST_WR1;
            end else begin
              state_nxt = ST_WR1;
            end
            res_nxt = inrange ? ent : END_MARK;
          end
        endcase
      end
      ST_WR1: begin
        if (inrange) begin
          mreq.en    = 1'b1;
          mreq.we    = 1'b1;
          mreq.addr  = off_r + 13'd1;
          mreq.wdata = lo_r;
        end
        if (op_r.func == FN_FREE) begin
          cur_nxt   = res_r;
          cnt_nxt   = cnt_r + 12'd1;
          res_nxt   = '0;
          state_nxt = ST_LOC;
        end else begin
          res_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid              = 1'b1;
        out_item.read_byte     = rb_r;
        out_item.entry         = (op_r.func == FN_GET) ? res_r : 12'h000;
        out_item.found_cluster = (op_r.func == FN_FIND) ? res_r : 12'h000;
        out_item.freed_count   = (op_r.func == FN_FREE) ? cnt_r : 12'h000;
        out_item.dirty         = dirty_r;
        state_nxt              = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `ASSERT_IMPL(a_done_valid, state_r == ST_DONE, out_valid, "done without result strobe")
  `ASSERT_NEXT(a_one_strobe, out_valid, !out_valid, "result strobe held two cycles")
endmodule

// ===== rtl/core/fat12_cluster_table_engine.sv =====
// top level of the fat12 cluster table engine
// depends on fat12_pkg, fat12_ram, fat12_seq
//
// command interface: raise start with in_item while busy is low; the
// transaction is taken at that edge and busy rises the next cycle.
// each transaction gives one result on out_item, flagged by out_valid for
// exactly one cycle; the receiver cannot stall, so the result must be taken.
// configuration: cfg_valid/cfg_ready write the cluster count (index 0) and
// fat_sectors (index 1); cfg_ready is always high, write only while idle.
// steps of a transaction: load, clean and unused func go from idle to done;
// read byte passes through wait; get and set locate the entry, read its two
// bytes (rd0, rd1) and evaluate, and set then writes both bytes back (eval, wr1);
// find free repeats loc to eval for each cluster scanned and free chain loc to
// wr1 for each link; out-of-range entries skip the reads and writes. the single
// byte port of the table ram sets these steps. the result shows in the done state.
// reset (rst_n low, synchronous) clears the sequencer, dirty flag and
// registers to cluster count 0, fat_sectors 1; the table ram is not
// cleared and must be loaded before it is read.
`include "assert_macros.svh"
module fat12_cluster_table_engine #(
  parameter int TABLE_BYTES = fat12_pkg::TABLE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  fat12_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output fat12_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [11:0]          cfg_data
);
  import fat12_pkg::*;

  localparam int AW = $clog2(TABLE_BYTES);

  logic [11:0] num_clusters_r;
  logic [3:0]  fat_sectors_r;
  mem_req_t    mreq;
  logic [7:0]  mrdata;

  assign cfg_ready = 1'b1;

  // register writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_clusters_r <= '0;
      fat_sectors_r  <= 4'd1;
    end else if (cfg_valid && cfg_index[1] == 1'b0) begin
      if (cfg_idx_t'(cfg_index[0]) == CFG_TOTAL) begin
        num_clusters_r <= cfg_data;
      end else begin
        fat_sectors_r <= cfg_data[3:0];
      end
    end
  end

  fat12_ram #(.WIDTH(8), .DEPTH(TABLE_BYTES)) u_ram (
    .clk   (clk),
    .en    (mreq.en),
    .we    (mreq.we),
    .addr  (mreq.addr[AW-1:0]),
    .wdata (mreq.wdata),
    .rdata (mrdata)
  );

  fat12_seq #(.TABLE_BYTES(TABLE_BYTES)) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .num_clusters (num_clusters_r),
    .fat_sectors  (fat_sectors_r),
    .mreq         (mreq),
    .mrdata       (mrdata),
    .out_valid    (out_valid),
    .out_item     (out_item)
  );

  `ASSERT_IMPL(a_sectors_nz, 1'b1, fat_sectors_r != 4'd0 || $past(cfg_valid), "sector count zero without a write")
  `ASSERT_NEXT(a_no_strobe_idle, !busy && !out_valid && !start, !out_valid, "result without a transaction")
  `ASSERT_IMPL(a_strobe_busy, out_valid, busy, "result strobe while idle")
endmodule

// ===== verif/fat12_cluster_table_engine_test.sv =====
// self-checking testbench for fat12_cluster_table_engine
// depends on fat12_pkg and the engine rtl; needs no files or arguments
`timescale 1ns / 100ps

module fat12_cluster_table_engine_test;
  import fat12_pkg::*;

  localparam int STORE_BYTES = 6144;
  localparam int FILL_BYTES  = 512;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int SETTLE      = 50;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;

  fat12_cluster_table_engine u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // shadow copy of the table, dirty flag and registers
  logic [7:0]  shadow_fat [STORE_BYTES];
  logic        shadow_dirty;
  logic [11:0] shadow_total;
  logic [3:0]  shadow_sectors;

  out_item_t pending_results[$];
  int        mismatches;
  int        cycles;

  // usable table size in bytes
  function automatic int usable_bytes();
    int sz;
    sz = int'(shadow_sectors) * SECTOR_BYTES;
    return (sz > STORE_BYTES) ? STORE_BYTES : sz;
  endfunction

  // word offset of a cluster's entry, or -1 when the cluster is out of range or its word lies outside the table
  function automatic int entry_offset(input int c);
    int off;
    if (c < 2 || c - 2 >= int'(shadow_total)) return -1;
    off = (c * 3) / 2;
    if (off + 1 >= usable_bytes()) return -1;
    return off;
  endfunction

  function automatic logic [11:0] peek_entry(input int c);
    int off;
    logic [15:0] w;
    off = entry_offset(c);
    if (off < 0) return END_MARK;
    w = {shadow_fat[off + 1], shadow_fat[off]};
    return c[0] ? w[15:4] : w[11:0];
  endfunction

  task automatic poke_entry(input int c, input logic [11:0] v);
    int off;
    logic [15:0] w;
    off = entry_offset(c);
    if (off >= 0) begin
      w = {shadow_fat[off + 1], shadow_fat[off]};
      if (c[0]) w = {v, w[3:0]};
      else w = {w[15:12], v};
      shadow_fat[off]     = w[7:0];
      shadow_fat[off + 1] = w[15:8];
      shadow_dirty = 1'b1;
    end
  endtask

  // applies one command to the shadow state and returns the result it gives
  task automatic apply_command(input in_item_t cmd, output out_item_t res);
    int c;
    int cur;
    int nxt;
    int steps;
    res = '0;
    case (func_t'(cmd.func))
      FN_LOAD: if (cmd.byte_index < STORE_BYTES) shadow_fat[cmd.byte_index] = cmd.byte_value;
      FN_READ: if (cmd.byte_index < STORE_BYTES) res.read_byte = shadow_fat[cmd.byte_index];
      FN_GET:  res.entry = peek_entry(cmd.cluster);
      FN_SET:  poke_entry(cmd.cluster, cmd.entry_value);
      FN_FIND: begin
        // scan stops at the first free entry or the last valid cluster
        for (c = 2; c < int'(shadow_total) + 2 && c <= 4095; c++) begin
          if (peek_entry(c) == 12'h000) begin
            res.found_cluster = c[11:0];
            break;
          end
        end
      end
      FN_FREE: begin
        cur = cmd.cluster;
        steps = 0;
        while (cur >= 2 && cur < int'(CHAIN_END) && steps < int'(shadow_total)) begin
          nxt = peek_entry(cur);
          poke_entry(cur, 12'h000);
          cur = nxt;
          steps++;
        end
        res.freed_count = steps[11:0];
      end
      FN_CLEAN: shadow_dirty = 1'b0;
      default: ;
    endcase
    res.dirty = shadow_dirty;
  endtask

  // one command transaction; start stays high across back-to-back commands
  task automatic issue_command(input in_item_t cmd, input int gap);
    out_item_t res;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_command(cmd, res);
    pending_results.push_back(res);
  endtask

  task automatic issue(input in_item_t cmd);
    issue_command(cmd, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
  endtask

  function automatic in_item_t make_cmd(input func_t f, input int bidx, input int bval,
                                        input int clus, input int val);
    in_item_t cmd;
    cmd.func        = f;
    cmd.byte_index  = bidx[12:0];
    cmd.byte_value  = bval[7:0];
    cmd.cluster     = clus[11:0];
    cmd.entry_value = val[11:0];
    return cmd;
  endfunction

  // stop sending and wait until every result is back, then let the engine settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write, only called once the engine has drained; valid stays up
  // for a following write and is dropped by the caller
  task automatic write_reg(input cfg_idx_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= 2'(idx);
    cfg_data  <= value[11:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_TOTAL) shadow_total = value[11:0];
    else shadow_sectors = value[3:0];
  endtask

  task automatic configure(input int total, input int sectors);
    drain();
    write_reg(CFG_TOTAL, total);
    write_reg(CFG_SECTORS, sectors);
    cfg_valid <= 1'b0;
  endtask

  // result checker: every strobe must match the oldest pending expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        want = pending_results.pop_front();
        if (out_item.read_byte !== want.read_byte || out_item.entry !== want.entry ||
            out_item.found_cluster !== want.found_cluster ||
            out_item.freed_count !== want.freed_count || out_item.dirty !== want.dirty) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected rb %h ent %h found %h freed %h dirty %b, got %p",
                     want.read_byte, want.entry, want.found_cluster, want.freed_count,
                     want.dirty, out_item);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // fill the first sector once; later phases keep every entry they can read
  // inside it, and byte reads stay there too, but for reads past the store and
  // of a byte loaded beforehand; zero-heavy so free entries turn up early in a scan
  task automatic test_table_fill();
    int i;
    for (i = 0; i < FILL_BYTES; i++)
      issue_command(make_cmd(FN_LOAD, i, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 255),
                             0, 0), ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : 0);
  endtask

  // extremes of the fields, every func, out-of-range cases
  task automatic test_directed();
    configure(100, 1);
    issue(make_cmd(FN_LOAD, 8191, 8'hAA, 0, 0));       // load past the store is ignored
    issue(make_cmd(FN_READ, 8191, 0, 0, 0));           // read past the store gives 0
    issue(make_cmd(FN_LOAD, 0, 255, 0, 0));
    issue(make_cmd(FN_READ, 0, 0, 0, 0));
    issue(make_cmd(FN_LOAD, 6143, 8'h5A, 0, 0));       // last byte of the store
    issue(make_cmd(FN_READ, 6143, 0, 0, 0));
    issue(make_cmd(FN_SET, 0, 0, 2, 12'hFFF));         // even cluster
    issue(make_cmd(FN_SET, 0, 0, 3, 12'hABC));         // odd cluster shares a byte
    issue(make_cmd(FN_GET, 0, 0, 2, 0));
    issue(make_cmd(FN_GET, 0, 0, 3, 0));
    issue(make_cmd(FN_CLEAN, 0, 0, 0, 0));
    issue(make_cmd(FN_SET, 0, 0, 1, 12'h123));         // below 2: ignored, stays clean
    issue(make_cmd(FN_SET, 0, 0, 102, 12'h123));       // beyond the cluster count
    issue(make_cmd(FN_GET, 0, 0, 0, 0));
    issue(make_cmd(FN_GET, 0, 0, 4095, 0));
    issue(make_cmd(FN_SET, 0, 0, 101, 12'h000));       // last valid cluster
    issue(make_cmd(FN_FIND, 0, 0, 0, 0));
    issue(make_cmd(FN_SET, 0, 0, 4, 5));               // chain 4 -> 5 -> end
    issue(make_cmd(FN_SET, 0, 0, 5, 12'hFF8));
    issue(make_cmd(FN_FREE, 0, 0, 4, 0));
    issue(make_cmd(FN_FREE, 0, 0, 12'hFF8, 0));        // starts at end mark
    issue(make_cmd(FN_SET, 0, 0, 6, 6));               // self loop ends once the freed entry reads back as 0
    issue(make_cmd(FN_FREE, 0, 0, 6, 0));
    issue(make_cmd(FN_NOP, 0, 0, 0, 0));
    // table end check: clusters 341 and up need bytes past the first sector
    configure(4084, 1);
    issue(make_cmd(FN_SET, 0, 0, 341, 12'h777));
    issue(make_cmd(FN_GET, 0, 0, 341, 0));
    issue(make_cmd(FN_GET, 0, 0, 340, 0));
    // no valid cluster at all: find gives none, free takes no step
    configure(0, 12);
    issue(make_cmd(FN_FIND, 0, 0, 0, 0));
    issue(make_cmd(FN_FREE, 0, 0, 2, 0));
  endtask

  function automatic in_item_t random_cmd();
    int r;
    int top;
    in_item_t cmd;
    top = int'(shadow_total) + 3;
    if (top > 4095) top = 4095;
    cmd.byte_index  = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(6144, 8191))
                                                  : 13'($urandom_range(0, FILL_BYTES - 1));
    cmd.byte_value  = 8'($urandom_range(0, 255));
    cmd.cluster     = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                                  : 12'($urandom_range(0, top));
    r = $urandom_range(0, 9);
    cmd.entry_value = (r < 3) ? 12'h000 : (r < 5) ? 12'(12'hFF8 + $urandom_range(0, 7))
                                                  : 12'($urandom_range(0, 4095));
    r = $urandom_range(0, 99);
    if (r < 15) cmd.func = FN_LOAD;
    else if (r < 27) cmd.func = FN_READ;
    else if (r < 45) cmd.func = FN_GET;
    else if (r < 70) cmd.func = FN_SET;
    else if (r < 74) cmd.func = FN_FIND;
    else if (r < 79) cmd.func = FN_FREE;
    else if (r < 86) cmd.func = FN_CLEAN;
    else if (r < 89) cmd.func = FN_NOP;
    else cmd.func = 3'($urandom_range(0, 7));
    return cmd;
  endfunction

  // well-formed chain: links through random valid clusters, then freed
  task automatic build_and_free_chain();
    int len;
    int k;
    int cur;
    int nxt;
    int first;
    len = $urandom_range(1, 6);
    first = $urandom_range(2, int'(shadow_total) + 1);
    cur = first;
    for (k = 1; k < len; k++) begin
      nxt = $urandom_range(2, int'(shadow_total) + 1);
      issue(make_cmd(FN_SET, 0, 0, cur, nxt));
      cur = nxt;
    end
    issue(make_cmd(FN_SET, 0, 0, cur, 12'hFF8 + $urandom_range(0, 7)));
    issue(make_cmd(FN_FREE, 0, 0, first, 0));
    if ($urandom_range(0, 1) == 0) issue(make_cmd(FN_GET, 0, 0, first, 0));
  endtask

  task automatic test_random_phase(input int total, input int sectors, input int count);
    int n;
    configure(total, sectors);
    n = 0;
    while (n < count) begin
      if (total > 2 && $urandom_range(0, 9) == 0) begin
        build_and_free_chain();
        n += 4;
      end else begin
        issue(random_cmd());
        n++;
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    mismatches = 0;
    cycles = 0;
    shadow_dirty = 1'b0;
    shadow_total = 12'd0;
    shadow_sectors = 4'd1;
    foreach (shadow_fat[i]) shadow_fat[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_fill();
    test_directed();
    // larger tables keep the cluster count low enough to stay in the filled sector
    test_random_phase(4084, 1, 200);
    test_random_phase(200, 1, 200);
    test_random_phase(339, 12, 200);
    test_random_phase(3, 12, 100);
    test_random_phase(339, 6, 150);
    test_random_phase(0, 1, 50);

    drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== fat12_cluster_table_engine.f =====
+incdir+rtl/core
rtl/core/fat12_pkg.sv
rtl/core/fat12_ram.sv
rtl/core/fat12_seq.sv
rtl/core/fat12_cluster_table_engine.sv
verif/fat12_cluster_table_engine_test.sv
